[hw/rtl/gnig_pkg.sv]
// gnig_pkg: shared constants, register codes and control types for the
// grid neighbor index generator. No dependencies.
package gnig_pkg;

  // defaults for the top-level parameters
  localparam int DEF_MAX_DIMS   = 4;
  localparam int DEF_CELL_BITS  = 24;
  localparam int DEF_COORD_BITS = 12;

  // fixed by the register and field layout
  localparam int NUM_OUT_DIMS = 4;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 13;
  localparam int DIMS_W       = 3;
  localparam int SIZE_W       = 13;
  localparam int PMASK_W      = 4;
  localparam int IN_TDATA_W   = 8;

  // depth of the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DIMS     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE0    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE1    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE2    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE3    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIODIC = 3'd5;

  // control from the configuration block to front and back
  typedef struct packed {
    logic busy;          // geometry being derived, hold off new items
    logic walk_restart;  // register written, walk goes back to cell 0
  } gnig_ctl_t;

endpackage

[hw/rtl/grid_neighbor_index_generator.sv]
// grid_neighbor_index_generator: top level of the stencil neighbor index walker.
// Uses gnig_pkg and instantiates gnig_derive, gnig_front and gnig_back.
//
// Each accepted input item produces one result item: the linear number of the
// current cell of a row-major grid (last dimension fastest) and, for each of
// four dimensions, its lower and upper neighbor numbers, -1 where there is none
// (free edge or unused dimension) or wrapped to the far edge where the
// dimension is periodic; tlast marks the final cell, after which the walk
// returns to cell 0, and an item with restart set starts over at cell 0 first.
// Items stream at one per cycle: the front takes an item into a two-entry
// queue whenever the queue has room and no derivation is under way, and the
// back, while the output is taken, produces one result per cycle into an
// output register, so stalls on either side stay local. After reset and after
// every write to one of the six registers the strides and wrap widths are
// recomputed one dimension per cycle on a shared multiplier pair, which keeps
// in_tready low from the write until the last dimension is done; such a write
// also moves the walk back to cell 0, while a write to an index past the
// register list changes nothing and does not stall the input.
module grid_neighbor_index_generator import gnig_pkg::*; #(
  parameter int MAX_DIMS     = DEF_MAX_DIMS,
  parameter int CELL_BITS    = DEF_CELL_BITS,
  parameter int COORD_BITS   = DEF_COORD_BITS,
  localparam int OUT_TDATA_W =
    ((CELL_BITS + 2 * NUM_OUT_DIMS * (CELL_BITS + 1) + 7) / 8) * 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // configuration write port
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  // input stream
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // restart, then zero padding
  // result stream
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // cell_res, lower0, upper0, lower1, upper1, lower2, upper2, lower3, upper3
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tlast   // last_cell
);

  localparam int SZ_W  = COORD_BITS + 1;
  localparam int DIM_W = $clog2(MAX_DIMS + 1);

  gnig_ctl_t            ctl;
  logic [DIM_W-1:0]     eff_dims;
  logic [SZ_W-1:0]      eff_size [MAX_DIMS];
  logic [PMASK_W-1:0]   pmask;
  logic [CELL_BITS-1:0] stride   [MAX_DIMS];
  logic [CELL_BITS-1:0] wrap     [MAX_DIMS];
  logic                 q_valid;
  logic                 q_restart;
  logic                 q_pop;

  // registers and geometry derivation
  gnig_derive #(
    .MAX_DIMS   (MAX_DIMS),
    .CELL_BITS  (CELL_BITS),
    .COORD_BITS (COORD_BITS)
  ) u_derive (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .ctl       (ctl),
    .eff_dims  (eff_dims),
    .eff_size  (eff_size),
    .pmask     (pmask),
    .stride    (stride),
    .wrap      (wrap)
  );

  // input side: accept items into the queue
  gnig_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_valid   (q_valid),
    .q_restart (q_restart),
    .q_pop     (q_pop)
  );

  // output side: walk the grid and form neighbor indices
  gnig_back #(
    .MAX_DIMS   (MAX_DIMS),
    .CELL_BITS  (CELL_BITS),
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .eff_dims   (eff_dims),
    .eff_size   (eff_size),
    .pmask      (pmask),
    .stride     (stride),
    .wrap       (wrap),
    .q_valid    (q_valid),
    .q_restart  (q_restart),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

[hw/rtl/gnig_derive.sv]
// gnig_derive: configuration registers and the sequencer that derives
// strides and wrap widths, one dimension per cycle. Uses gnig_pkg.
module gnig_derive import gnig_pkg::*; #(
  parameter int MAX_DIMS   = DEF_MAX_DIMS,
  parameter int CELL_BITS  = DEF_CELL_BITS,
  parameter int COORD_BITS = DEF_COORD_BITS,
  localparam int SZ_W      = COORD_BITS + 1,
  localparam int DIM_W     = $clog2(MAX_DIMS + 1)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output gnig_ctl_t             ctl,
  output logic [DIM_W-1:0]      eff_dims,
  output logic [SZ_W-1:0]       eff_size [MAX_DIMS],
  output logic [PMASK_W-1:0]    pmask,
  output logic [CELL_BITS-1:0]  stride   [MAX_DIMS],
  output logic [CELL_BITS-1:0]  wrap     [MAX_DIMS]
);

  localparam int STEP_W = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int CMP_W  = (SIZE_W > SZ_W) ? SIZE_W : SZ_W;
  localparam int PROD_W = CELL_BITS + SZ_W;
  localparam logic [CMP_W-1:0] SIZE_LIM = CMP_W'(1) << COORD_BITS;

  logic [DIMS_W-1:0]    dims_r;
  logic [SIZE_W-1:0]    size_r [NUM_OUT_DIMS];
  logic [PMASK_W-1:0]   pmask_r;
  logic                 busy_r;
  logic [STEP_W-1:0]    step_r;
  logic [CELL_BITS-1:0] run_r;
  logic [CELL_BITS-1:0] run_nxt;
  logic [CELL_BITS-1:0] stride_r [MAX_DIMS];
  logic [CELL_BITS-1:0] wrap_r   [MAX_DIMS];
  logic [CELL_BITS-1:0] stride_nxt;
  logic [CELL_BITS-1:0] wrap_nxt;
  logic [SZ_W-1:0]      sel_size;
  logic [PROD_W-1:0]    prod_run;
  logic [PROD_W-1:0]    prod_wrap;
  logic                 step_used;
  logic                 cfg_hit;

  assign cfg_hit = cfg_we && (cfg_index <= CFG_PERIODIC);

  // clamp sizes and dimension count
  always_comb begin
    logic [CMP_W-1:0] s;
    for (int j = 0; j < MAX_DIMS; j++) begin
      s = CMP_W'(size_r[j]);
      if (s == '0) begin
        eff_size[j] = SZ_W'(1);
      end else if (s > SIZE_LIM) begin
        eff_size[j] = SZ_W'(SIZE_LIM);
      end else begin
        eff_size[j] = SZ_W'(s);
      end
    end
  end

  always_comb begin
    if (dims_r == '0) begin
      eff_dims = DIM_W'(1);
    end else if (int'(dims_r) > MAX_DIMS) begin
      eff_dims = DIM_W'(MAX_DIMS);
    end else begin
      eff_dims = DIM_W'(dims_r);
    end
  end

  // one dimension per step, fastest first
  assign sel_size   = eff_size[step_r];
  assign step_used  = DIM_W'(step_r) < eff_dims;
  assign prod_run   = PROD_W'(run_r) * PROD_W'(sel_size);
  assign prod_wrap  = PROD_W'(run_r) * PROD_W'(sel_size - SZ_W'(1));
  assign run_nxt    = step_used ? prod_run[CELL_BITS-1:0] : run_r;
  assign stride_nxt = step_used ? run_r : '0;
  assign wrap_nxt   = step_used ? prod_wrap[CELL_BITS-1:0] : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dims_r  <= DIMS_W'(1);
      for (int j = 0; j < NUM_OUT_DIMS; j++) begin
        size_r[j] <= SIZE_W'(1);
      end
      pmask_r <= '0;
      busy_r  <= 1'b1;
      step_r  <= STEP_W'(MAX_DIMS - 1);
      run_r   <= CELL_BITS'(1);
    end else if (cfg_hit) begin
      unique case (cfg_index)
        CFG_DIMS:     dims_r    <= cfg_wdata[DIMS_W-1:0];
        CFG_SIZE0:    size_r[0] <= cfg_wdata[SIZE_W-1:0];
        CFG_SIZE1:    size_r[1] <= cfg_wdata[SIZE_W-1:0];
        CFG_SIZE2:    size_r[2] <= cfg_wdata[SIZE_W-1:0];
        CFG_SIZE3:    size_r[3] <= cfg_wdata[SIZE_W-1:0];
        CFG_PERIODIC: pmask_r   <= cfg_wdata[PMASK_W-1:0];
        default: ;
      endcase
      busy_r <= 1'b1;
      step_r <= STEP_W'(MAX_DIMS - 1);
      run_r  <= CELL_BITS'(1);
    end else if (busy_r) begin
      run_r <= run_nxt;
      if (step_r == '0) begin
        busy_r <= 1'b0;
      end else begin
        step_r <= step_r - STEP_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy_r && !cfg_hit) begin
      stride_r[step_r] <= stride_nxt;
      wrap_r[step_r]   <= wrap_nxt;
    end
  end

  assign ctl.busy         = busy_r | cfg_hit;
  assign ctl.walk_restart = cfg_hit;
  assign pmask            = pmask_r;
  assign stride           = stride_r;
  assign wrap             = wrap_r;

endmodule

[hw/rtl/gnig_front.sv]
// gnig_front: input handshake, restart flag extraction and the short queue
// that decouples the input from the walk. Uses gnig_pkg.
module gnig_front import gnig_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  gnig_ctl_t             ctl,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_TDATA_W-1:0] in_tdata,
  output logic                  q_valid,
  output logic                  q_restart,
  input  logic                  q_pop
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic             entry_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             push;

  assign in_tready = !ctl.busy && (count_r != CNT_W'(QUEUE_DEPTH));
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (count_r != '0);
  assign q_restart = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (q_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (push && !q_pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (q_pop && !push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= in_tdata[0];
    end
  end

endmodule

[hw/rtl/gnig_back.sv]
// gnig_back: grid walk state, neighbor arithmetic and the output register.
// Uses gnig_pkg; geometry comes from gnig_derive.
module gnig_back import gnig_pkg::*; #(
  parameter int MAX_DIMS    = DEF_MAX_DIMS,
  parameter int CELL_BITS   = DEF_CELL_BITS,
  parameter int COORD_BITS  = DEF_COORD_BITS,
  localparam int SZ_W       = COORD_BITS + 1,
  localparam int DIM_W      = $clog2(MAX_DIMS + 1),
  localparam int NB_W       = CELL_BITS + 1,
  localparam int OUT_TDATA_W = ((CELL_BITS + 2 * NUM_OUT_DIMS * NB_W + 7) / 8) * 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  gnig_ctl_t              ctl,
  input  logic [DIM_W-1:0]       eff_dims,
  input  logic [SZ_W-1:0]        eff_size [MAX_DIMS],
  input  logic [PMASK_W-1:0]     pmask,
  input  logic [CELL_BITS-1:0]   stride   [MAX_DIMS],
  input  logic [CELL_BITS-1:0]   wrap     [MAX_DIMS],
  input  logic                   q_valid,
  input  logic                   q_restart,
  output logic                   q_pop,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tlast
);

  logic [COORD_BITS-1:0]  coord_r  [MAX_DIMS];
  logic [COORD_BITS-1:0]  coord_nxt [MAX_DIMS];
  logic [COORD_BITS-1:0]  cur_coord [MAX_DIMS];
  logic [CELL_BITS-1:0]   cell_r;
  logic [CELL_BITS-1:0]   cell_nxt;
  logic [CELL_BITS-1:0]   cur_cell;
  logic [NB_W-1:0]        nb_lo [NUM_OUT_DIMS];
  logic [NB_W-1:0]        nb_hi [NUM_OUT_DIMS];
  logic [NUM_OUT_DIMS-1:0] at_hi;
  logic [NUM_OUT_DIMS-1:0] done;
  logic                   last;
  logic                   out_valid_r;
  logic [OUT_TDATA_W-1:0] data_r;
  logic [OUT_TDATA_W-1:0] data_nxt;
  logic                   last_r;

  assign q_pop    = q_valid && (!out_valid_r || out_tready);
  assign cur_cell = q_restart ? '0 : cell_r;

  for (genvar j = 0; j < NUM_OUT_DIMS; j++) begin : g_dim
    if (j < MAX_DIMS) begin : g_used
      logic used;
      logic per;
      logic at_lo;
      assign cur_coord[j] = q_restart ? '0 : coord_r[j];
      assign used  = eff_dims > DIM_W'(j);
      assign per   = pmask[j];
      assign at_lo = (cur_coord[j] == '0);
      assign at_hi[j] = (SZ_W'(cur_coord[j]) + SZ_W'(1)) >= eff_size[j];
      assign done[j]  = !used || at_hi[j];
      always_comb begin
        if (!used) begin
          nb_lo[j] = '1;
        end else if (!at_lo) begin
          nb_lo[j] = {1'b0, cur_cell - stride[j]};
        end else if (per) begin
          nb_lo[j] = {1'b0, cur_cell + wrap[j]};
        end else begin
          nb_lo[j] = '1;
        end
        if (!used) begin
          nb_hi[j] = '1;
        end else if (!at_hi[j]) begin
          nb_hi[j] = {1'b0, cur_cell + stride[j]};
        end else if (per) begin
          nb_hi[j] = {1'b0, cur_cell - wrap[j]};
        end else begin
          nb_hi[j] = '1;
        end
      end
    end else begin : g_absent
      assign at_hi[j] = 1'b1;
      assign done[j]  = 1'b1;
      assign nb_lo[j] = '1;
      assign nb_hi[j] = '1;
    end
  end

  assign last = &done;

  // odometer step, fastest used dimension first
  always_comb begin
    logic carry;
    carry = 1'b1;
    for (int j = MAX_DIMS - 1; j >= 0; j--) begin
      coord_nxt[j] = cur_coord[j];
      if (last) begin
        coord_nxt[j] = '0;
      end else if (carry && (eff_dims > DIM_W'(j))) begin
        if (at_hi[j]) begin
          coord_nxt[j] = '0;
        end else begin
          coord_nxt[j] = cur_coord[j] + COORD_BITS'(1);
          carry = 1'b0;
        end
      end
    end
    cell_nxt = last ? '0 : cur_cell + CELL_BITS'(1);
  end

  always_comb begin
    data_nxt = '0;
    data_nxt[CELL_BITS-1:0] = cur_cell;
    for (int j = 0; j < NUM_OUT_DIMS; j++) begin
      data_nxt[CELL_BITS + 2 * j * NB_W +: NB_W]       = nb_lo[j];
      data_nxt[CELL_BITS + (2 * j + 1) * NB_W +: NB_W] = nb_hi[j];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < MAX_DIMS; j++) begin
        coord_r[j] <= '0;
      end
      cell_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (ctl.walk_restart) begin
        for (int j = 0; j < MAX_DIMS; j++) begin
          coord_r[j] <= '0;
        end
        cell_r <= '0;
      end else if (q_pop) begin
        coord_r <= coord_nxt;
        cell_r  <= cell_nxt;
      end
      if (q_pop) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      data_r <= data_nxt;
      last_r <= last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = data_r;
  assign out_tlast  = last_r;

endmodule
